// ----- rtl/core/prb_pkg.sv -----
// shared types and constants for the packbits row decoder
`default_nettype none

package prb_pkg;

  // field widths
  localparam int CODE_W   = 8;
  localparam int LEN_W    = 8;
  localparam int OFFSET_W = 14;
  localparam int STRIDE_W = 3;

  // default sizing
  localparam int ROW_MAX_DEF    = 4096;
  localparam int MAX_STRIDE_DEF = 4;
  localparam int FIFO_DEPTH_DEF = 2;

  // stride register reset value
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 3'd1;

  // header codes
  localparam logic [CODE_W-1:0] HDR_NOP  = 8'h80;
  localparam logic [CODE_W:0]   RUN_BASE = 9'd257;

  // command passed from the classifier to the writer stage
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  want;
    logic              emit;
    logic              last;
  } cmd_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/packbits_row_decoder.sv -----
// PackBits row decoder top level
// Input channel: one compressed byte per transaction on in_code_byte, with
// in_last_of_row marking the final byte of a row. A transaction completes at
// a clock edge with in_valid high and in_stall low.
// Result channel: one write command per literal byte or run byte (value,
// byte offset, run length), plus one command on every row end, which carries
// row_done and a length of zero if no write came with it.
// cfg_we loads cfg_output_stride; write it only while the block is idle.
// The classifier is combinational, so the command enters the two-entry queue
// at the input edge; it moves on into the result register once that register
// is free or being taken, so out_stall can hold it in the queue.
// One byte is taken every cycle while out_stall is low; the writer stage's
// position update sets the one-command-per-cycle rate.
// Reset (rst_n low at a clock edge) returns to the header phase at output
// position zero, empties the queue and sets the stride to 1.
// When out_stall is high the result holds; the queue fills and in_stall
// rises once both queue entries are occupied, and it stays high for the
// cycle in which the first entry moves on.
`default_nettype none

module packbits_row_decoder #(
  parameter int ROW_MAX    = prb_pkg::ROW_MAX_DEF,
  parameter int MAX_STRIDE = prb_pkg::MAX_STRIDE_DEF,
  parameter int FIFO_DEPTH = prb_pkg::FIFO_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire  [prb_pkg::STRIDE_W-1:0]  cfg_output_stride,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [prb_pkg::CODE_W-1:0]    in_code_byte,
  input  wire                           in_last_of_row,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [prb_pkg::CODE_W-1:0]    out_value,
  output logic [prb_pkg::OFFSET_W-1:0]  out_write_offset,
  output logic [prb_pkg::LEN_W-1:0]     out_run_length,
  output logic                          out_row_done,
  output logic                          out_overflow
);

  prb_pkg::fifo_stat_t q_stat;
  prb_pkg::cmd_t       push_cmd;
  prb_pkg::cmd_t       head_cmd;
  logic                q_push;
  logic                q_pop;

  // classifier
  prb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_byte  (in_code_byte),
    .in_last_of_row(in_last_of_row),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // command queue
  prb_cmd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .stat    (q_stat)
  );

  // writer stage
  prb_back #(
    .ROW_MAX   (ROW_MAX),
    .MAX_STRIDE(MAX_STRIDE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_output_stride(cfg_output_stride),
    .q_stat           (q_stat),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_write_offset (out_write_offset),
    .out_run_length   (out_run_length),
    .out_row_done     (out_row_done),
    .out_overflow     (out_overflow)
  );

`ifndef SYNTHESIS
  // queue status is never full and empty at once
  a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("command queue reports full and empty");

  // a popped command always lands in the result register
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("popped command did not reach the output");

  // a zero-length result without overflow only comes from a row end
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_length == '0 && !out_overflow) |->
      (out_row_done && out_value == '0))
    else $error("zero-length write without row end");

  // run length never exceeds one packbits run
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length <= prb_pkg::LEN_W'(128)))
    else $error("run length above 128");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/prb_front.sv -----
// header classifier: tracks literal/run phase and issues write commands
`default_nettype none

module prb_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [prb_pkg::CODE_W-1:0]   in_code_byte,
  input  wire                          in_last_of_row,
  input  prb_pkg::fifo_stat_t          q_stat,
  output logic                         q_push,
  output prb_pkg::cmd_t                q_cmd
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_RUN     = 2'd2;

  logic [1:0]                  phase_r, phase_nxt;
  logic [prb_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [prb_pkg::LEN_W-1:0]   rem_dec;
  logic [prb_pkg::CODE_W:0]    run_cnt;
  logic                        accept;
  logic                        emit;
  logic [prb_pkg::LEN_W-1:0]   want;

  // take a byte whenever the queue has room
  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~q_stat.full;

  assign rem_dec = (rem_r != '0) ? rem_r - prb_pkg::LEN_W'(1) : rem_r;
  assign run_cnt = prb_pkg::RUN_BASE - {1'b0, in_code_byte};

  // phase decode for the current byte
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    want      = '0;
    unique case (phase_r)
      PH_LITERAL: begin
        emit    = 1'b1;
        want    = prb_pkg::LEN_W'(1);
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_HEADER;
      end
      PH_RUN: begin
        emit      = 1'b1;
        want      = rem_r;
        rem_nxt   = '0;
        phase_nxt = PH_HEADER;
      end
      default: begin
        if (in_code_byte > prb_pkg::HDR_NOP) begin
          rem_nxt   = run_cnt[prb_pkg::LEN_W-1:0];
          phase_nxt = PH_RUN;
        end else if (in_code_byte < prb_pkg::HDR_NOP) begin
          rem_nxt   = in_code_byte + prb_pkg::LEN_W'(1);
          phase_nxt = PH_LITERAL;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    endcase
    // row end returns to the header phase
    if (in_last_of_row) begin
      phase_nxt = PH_HEADER;
      rem_nxt   = '0;
    end
  end

  // command toward the writer stage
  assign q_push     = accept & (emit | in_last_of_row);
  assign q_cmd.code = in_code_byte;
  assign q_cmd.want = want;
  assign q_cmd.emit = emit;
  assign q_cmd.last = in_last_of_row;

  // phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      rem_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/prb_cmd_fifo.sv -----
// short command queue between classifier and writer stage
`default_nettype none

module prb_cmd_fifo #(
  parameter int DEPTH = prb_pkg::FIFO_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  prb_pkg::cmd_t        push_cmd,
  input  wire                  pop,
  output prb_pkg::cmd_t        head_cmd,
  output prb_pkg::fifo_stat_t  stat
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  prb_pkg::cmd_t   mem_r [DEPTH];
  logic [IdxW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == CntW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + IdxW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CntW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ----- rtl/core/prb_back.sv -----
// writer stage: output position, clipping, strided offset and result register
`default_nettype none

module prb_back #(
  parameter int ROW_MAX    = prb_pkg::ROW_MAX_DEF,
  parameter int MAX_STRIDE = prb_pkg::MAX_STRIDE_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire  [prb_pkg::STRIDE_W-1:0]  cfg_output_stride,
  input  prb_pkg::fifo_stat_t           q_stat,
  input  prb_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [prb_pkg::CODE_W-1:0]    out_value,
  output logic [prb_pkg::OFFSET_W-1:0]  out_write_offset,
  output logic [prb_pkg::LEN_W-1:0]     out_run_length,
  output logic                          out_row_done,
  output logic                          out_overflow
);

  localparam int PosW  = $clog2(ROW_MAX + 1);
  localparam int CmpW  = ((PosW > prb_pkg::LEN_W) ? PosW : prb_pkg::LEN_W) + 1;
  localparam int ProdW = PosW + prb_pkg::STRIDE_W;

  logic [prb_pkg::STRIDE_W-1:0] stride_r;
  logic [prb_pkg::STRIDE_W-1:0] stride_eff;
  logic [PosW-1:0]              pos_r, pos_nxt;
  logic [CmpW-1:0]              room;
  logic [CmpW-1:0]              want_x;
  logic [CmpW-1:0]              len_x;
  logic                         ovf;
  logic [ProdW-1:0]             prod;
  logic [prb_pkg::OFFSET_W-1:0] offset;
  logic                         load;
  logic                         out_valid_r;

  // stride register
  always_ff @(posedge clk) begin
    if (!rst_n) stride_r <= prb_pkg::STRIDE_RESET;
    else if (cfg_we) stride_r <= cfg_output_stride;
  end

  // stride clamp
  always_comb begin
    stride_eff = stride_r;
    if (stride_r == '0) stride_eff = prb_pkg::STRIDE_W'(1);
    else if (stride_r > prb_pkg::STRIDE_W'(MAX_STRIDE)) stride_eff = prb_pkg::STRIDE_W'(MAX_STRIDE);
  end

  // clip the run to the positions left in the row
  assign room   = (CmpW'(pos_r) < CmpW'(ROW_MAX)) ? CmpW'(ROW_MAX) - CmpW'(pos_r) : '0;
  assign want_x = q_cmd.emit ? CmpW'(q_cmd.want) : '0;
  assign ovf    = (want_x > room);
  assign len_x  = ovf ? room : want_x;

  // strided start offset
  assign prod   = ProdW'(pos_r) * ProdW'(stride_eff);
  assign offset = (len_x != '0) ? prb_pkg::OFFSET_W'(prod) : '0;

  // row end clears the position after this command
  assign pos_nxt = q_cmd.last ? '0 : pos_r + PosW'(len_x);

  // pop into the result register when it is free or being taken
  assign load  = ~q_stat.empty & (~out_valid_r | ~out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) pos_r <= pos_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_value        <= q_cmd.emit ? q_cmd.code : '0;
      out_write_offset <= offset;
      out_run_length   <= prb_pkg::LEN_W'(len_x);
      out_row_done     <= q_cmd.last;
      out_overflow     <= ovf;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
